>>> hdl/agpr_pkg.sv
// Shared types and constants for the audio gain/pan ramp block.
// Holds the transaction payload structs, function codes, register indexes
// and the sequencer state type. No dependencies.
package agpr_pkg;

    // Fixed field widths of the payload
    localparam int SAMPLE_BITS = 24;
    localparam int FUNC_W      = 2;
    localparam int Q14_W       = 16;
    localparam int LEN_W       = 13;
    localparam int CHCNT_W     = 5;
    localparam int CHAN_W      = 4;
    localparam int POS_W       = 12;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 1;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_CHANNELS = 16;
    localparam int DEF_MAX_BLOCK    = 4096;

    // Arithmetic widths
    localparam int MUL_W        = 32;              // shared multiplier operand width
    localparam int PROD_W       = 2 * MUL_W;
    localparam int FACTOR_W     = 2 * Q14_W;       // Q4.28 factor
    localparam int FACTOR_SHIFT = 28;
    localparam int POS1_W       = POS_W + 1;       // index + 1
    localparam int DVD_W        = FACTOR_W + POS1_W;
    localparam int QUO_W        = FACTOR_W;

    localparam logic [Q14_W-1:0] UNITY_Q14 = 16'd16384;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_BLOCK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHAN   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAN_COUNT  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_COUNT = 1'd1;

    typedef struct packed {
        logic [FUNC_W-1:0]             func;
        logic [Q14_W-1:0]              gain_target;
        logic [LEN_W-1:0]              block_length;
        logic [CHCNT_W-1:0]            channel_total;
        logic [CHAN_W-1:0]             channel_number;
        logic [Q14_W-1:0]              pan_target;
        logic [POS_W-1:0]              sample_position;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } t_agpr_in;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic [CHAN_W-1:0]             channel_out;
        logic                          clipped;
    } t_agpr_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CH_FROM,
        ST_CH_TO,
        ST_CH_STEP,
        ST_SMP_MUL,
        ST_SMP_DIV_LD,
        ST_SMP_DIV,
        ST_SMP_OUT
    } t_state;

endpackage

>>> hdl/audio_gain_pan_ramp.sv
// Audio gain/pan ramp: top level with sequencer and ramp state.
// Depends on agpr_pkg, agpr_mul and agpr_div.
//
// Usage: one input channel (i_in_valid / o_in_stall / i_in_data) carries
// block starts, channel starts and samples; one output channel
// (o_out_valid / i_out_stall / o_out_data) returns one scaled sample per
// sample transaction. Block starts and channel starts produce no output.
// A block start needs no work after accept. A channel start forms two
// products on the shared multiplier, then its signed step. A sample
// runs one multiply, a divider load, a bit-serial divide of the ramp
// term and one multiply for the scaling, then registers its result.
// The divider loop sets the sample rate.
// o_in_stall is high while a transaction is in work.
// Configuration (i_cfg_we / i_cfg_index / i_cfg_data) must be written
// only while idle; the block does not check it. Reset is synchronous, active
// low: it clears the ramp history, so the first block after reset does not
// ramp. When the receiver stalls, the result holds in the output register;
// the next sample finishes its arithmetic and then waits for it to free up.
module audio_gain_pan_ramp
    import agpr_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    parameter int MAX_BLOCK    = DEF_MAX_BLOCK
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_agpr_in             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_agpr_out            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int PAN_DEPTH = (MAX_CHANNELS < 16) ? MAX_CHANNELS : 16;
    localparam int PAN_IW    = (PAN_DEPTH > 1) ? $clog2(PAN_DEPTH) : 1;
    localparam int RND_W     = PROD_W - FACTOR_SHIFT;

    // Sequencer
    t_state r_state, n_state;

    // Configuration
    logic [CFG_W-1:0] r_pan_count;
    logic [CFG_W-1:0] r_ramp_count;

    // Ramp state
    logic                 r_applied_once;
    logic [Q14_W-1:0]     r_applied_gain;
    logic [Q14_W-1:0]     r_applied_pan [PAN_DEPTH];
    logic [Q14_W-1:0]     r_ramp_start_gain;
    logic                 r_ramp_active;
    logic [LEN_W-1:0]     r_block_samples;
    logic [CHCNT_W-1:0]   r_block_channels;
    logic [FACTOR_W-1:0]  r_from_factor;
    logic                 r_step_neg;
    logic [FACTOR_W-1:0]  r_step_mag;

    // Per-transaction working registers
    logic [Q14_W-1:0]       r_src_pan;
    logic [Q14_W-1:0]       r_to_pan;
    logic [POS1_W-1:0]      r_pos1;
    logic [SAMPLE_BITS-1:0] r_mag;
    logic                   r_neg;
    logic [CHAN_W-1:0]      r_chan;

    // Shared units
    logic              mul_en;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;
    logic              div_start;
    logic              div_done;
    logic [QUO_W-1:0]  div_q;

    // Handshake
    logic in_acc;
    logic out_free;
    logic out_load;

    // Decoded input
    logic                 ch_ok;
    logic                 ch_ramped;
    logic [PAN_IW-1:0]    ch_idx;
    logic [Q14_W-1:0]     to_pan;
    logic [Q14_W-1:0]     src_pan;
    logic [CHCNT_W-1:0]   blk_chans;
    logic [LEN_W-1:0]     blk_len;
    logic [POS1_W-1:0]    pos1;
    logic [SAMPLE_BITS-1:0] smp_mag;

    // Sample arithmetic
    logic [FACTOR_W-1:0]    factor;
    logic [PROD_W-1:0]      rsum;
    logic [RND_W-1:0]       rmag;
    logic [RND_W-1:0]       rlim;
    logic [RND_W-1:0]       rsat;
    logic                   clip;
    logic [SAMPLE_BITS-1:0] rres;
    logic [FACTOR_W:0]      step_diff;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;

    // Channel start decode: pan selection and ramp source
    always_comb begin
        ch_ok     = ({1'b0, i_in_data.channel_number} < r_block_channels)
                    && (32'(i_in_data.channel_number) < MAX_CHANNELS);
        ch_ramped = ({1'b0, i_in_data.channel_number} < r_ramp_count);
        ch_idx    = PAN_IW'(i_in_data.channel_number);
        if ((r_block_channels == CHCNT_W'(1))
            || ({1'b0, i_in_data.channel_number} >= r_pan_count)) begin
            to_pan = UNITY_Q14;
        end else begin
            to_pan = i_in_data.pan_target;
        end
        src_pan = (ch_ramped && r_ramp_active) ? r_applied_pan[ch_idx] : to_pan;
    end

    // Block start decode: clamp channel count and length
    always_comb begin
        if (32'(i_in_data.channel_total) > MAX_CHANNELS) begin
            blk_chans = CHCNT_W'(MAX_CHANNELS);
        end else begin
            blk_chans = i_in_data.channel_total;
        end
        if (i_in_data.block_length == '0) begin
            blk_len = LEN_W'(1);
        end else if (32'(i_in_data.block_length) > MAX_BLOCK) begin
            blk_len = LEN_W'(MAX_BLOCK);
        end else begin
            blk_len = i_in_data.block_length;
        end
    end

    // Sample decode: clamped index + 1 and sample magnitude
    always_comb begin
        pos1 = {1'b0, i_in_data.sample_position} + POS1_W'(1);
        if (pos1 > r_block_samples) begin
            pos1 = r_block_samples;
        end
        if (i_in_data.sample_in[SAMPLE_BITS-1]) begin
            smp_mag = ~i_in_data.sample_in + SAMPLE_BITS'(1);
        end else begin
            smp_mag = i_in_data.sample_in;
        end
    end

    // Ramp factor from the divided term, then rounding and saturation
    always_comb begin
        factor    = r_step_neg ? (r_from_factor - div_q) : (r_from_factor + div_q);
        rsum      = mul_p + (PROD_W'(1) << (FACTOR_SHIFT - 1));
        rmag      = rsum[PROD_W-1:FACTOR_SHIFT];
        rlim      = RND_W'(1) << (SAMPLE_BITS - 1);
        clip      = 1'b0;
        rsat      = rmag;
        if (!r_neg && (rmag > (rlim - RND_W'(1)))) begin
            rsat = rlim - RND_W'(1);
            clip = 1'b1;
        end else if (r_neg && (rmag > rlim)) begin
            rsat = rlim;
            clip = 1'b1;
        end
        rres      = r_neg ? (SAMPLE_BITS'(0) - rsat[SAMPLE_BITS-1:0])
                          : rsat[SAMPLE_BITS-1:0];
        step_diff = {1'b0, mul_p[FACTOR_W-1:0]} - {1'b0, r_from_factor};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if ((i_in_data.func == FUNC_CHAN) && ch_ok) begin
                        n_state = ST_CH_FROM;
                    end else if (i_in_data.func == FUNC_SAMPLE) begin
                        n_state = ST_SMP_MUL;
                    end
                end
            end
            ST_CH_FROM:    n_state = ST_CH_TO;
            ST_CH_TO:      n_state = ST_CH_STEP;
            ST_CH_STEP:    n_state = ST_IDLE;
            ST_SMP_MUL:    n_state = ST_SMP_DIV_LD;
            ST_SMP_DIV_LD: n_state = ST_SMP_DIV;
            ST_SMP_DIV: begin
                if (div_done) begin
                    n_state = ST_SMP_OUT;
                end
            end
            ST_SMP_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs: shared unit operands and strobes
    always_comb begin
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ST_CH_FROM: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(r_ramp_start_gain);
                mul_b  = MUL_W'(r_src_pan);
            end
            ST_CH_TO: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(r_applied_gain);
                mul_b  = MUL_W'(r_to_pan);
            end
            ST_SMP_MUL: begin
                mul_en = 1'b1;
                mul_a  = MUL_W'(r_step_mag);
                mul_b  = MUL_W'(r_pos1);
            end
            ST_SMP_DIV_LD: begin
                div_start = 1'b1;
            end
            ST_SMP_DIV: begin
                if (div_done) begin
                    mul_en = 1'b1;
                    mul_a  = MUL_W'(r_mag);
                    mul_b  = MUL_W'(factor);
                end
            end
            ST_SMP_OUT: begin
                out_load = out_free;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // Control and ramp state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_pan_count       <= '0;
            r_ramp_count      <= '0;
            r_applied_once    <= 1'b0;
            r_applied_gain    <= '0;
            for (int i = 0; i < PAN_DEPTH; i++) begin
                r_applied_pan[i] <= '0;
            end
            r_ramp_start_gain <= '0;
            r_ramp_active     <= 1'b0;
            r_block_samples   <= LEN_W'(1);
            r_block_channels  <= '0;
            r_from_factor     <= '0;
            r_step_neg        <= 1'b0;
            r_step_mag        <= '0;
            o_out_valid       <= 1'b0;
        end else begin
            r_state <= n_state;

            // Register writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_PAN_COUNT:  r_pan_count  <= i_cfg_data;
                    CFG_RAMP_COUNT: r_ramp_count <= i_cfg_data;
                    default:        r_pan_count  <= r_pan_count;
                endcase
            end

            // Block start and channel start bookkeeping
            if (in_acc) begin
                if ((i_in_data.func == FUNC_BLOCK) && (i_in_data.channel_total != '0)) begin
                    r_ramp_active     <= r_applied_once;
                    r_ramp_start_gain <= r_applied_once ? r_applied_gain
                                                        : i_in_data.gain_target;
                    r_applied_once    <= 1'b1;
                    r_applied_gain    <= i_in_data.gain_target;
                    r_block_samples   <= blk_len;
                    r_block_channels  <= blk_chans;
                end
                if ((i_in_data.func == FUNC_CHAN) && ch_ok && ch_ramped) begin
                    r_applied_pan[ch_idx] <= to_pan;
                end
            end

            // Start factor, then signed step to the target factor
            if (r_state == ST_CH_TO) begin
                r_from_factor <= mul_p[FACTOR_W-1:0];
            end
            if (r_state == ST_CH_STEP) begin
                r_step_neg <= step_diff[FACTOR_W];
                r_step_mag <= step_diff[FACTOR_W] ? (r_from_factor - mul_p[FACTOR_W-1:0])
                                                  : step_diff[FACTOR_W-1:0];
            end

            // Output register
            if (out_load) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Working payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_src_pan  <= src_pan;
            r_to_pan   <= to_pan;
            r_pos1     <= pos1;
            r_mag      <= smp_mag;
            r_neg      <= i_in_data.sample_in[SAMPLE_BITS-1];
            r_chan     <= i_in_data.channel_number;
        end
        if (out_load) begin
            o_out_data.sample_out  <= rres;
            o_out_data.channel_out <= r_chan;
            o_out_data.clipped     <= clip;
        end
    end

    // Shared multiplier
    agpr_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    // Ramp term divider: |step| * (index + 1) / length
    agpr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_p[DVD_W-1:0]),
        .i_divisor  (r_block_samples),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

endmodule

>>> hdl/agpr_mul.sv
// Shared unsigned multiplier with a registered product.
// Depends on agpr_pkg for the operand width.
module agpr_mul
    import agpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [MUL_W-1:0]  i_a,
    input  logic [MUL_W-1:0]  i_b,
    output logic [PROD_W-1:0] o_p
);

    logic [PROD_W-1:0] r_p;

    // Product register, updated only when an operation is issued
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

>>> hdl/agpr_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on agpr_pkg. The quotient must fit in QUO_W bits.
module agpr_div
    import agpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [LEN_W-1:0]  i_divisor,
    output logic              o_done,
    output logic [QUO_W-1:0]  o_quotient
);

    localparam int CNT_W = $clog2(QUO_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_quo;
    logic [LEN_W-1:0] r_div;

    logic [LEN_W:0]   trial;
    logic [LEN_W:0]   diff;
    logic             fits;

    // Shift in the next dividend bit and try a subtract
    always_comb begin
        trial = {r_rem, r_quo[QUO_W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(QUO_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath: upper dividend bits are below the divisor, so they seed the remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[DVD_W-1:QUO_W];
            r_quo <= i_dividend[QUO_W-1:0];
            r_div <= i_divisor;
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= fits ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
            r_quo <= {r_quo[QUO_W-2:0], fits};
        end
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for audio_gain_pan_ramp: random and directed block,
// channel and sample transactions, checked against a built-in ramp predictor.
// Depends on agpr_pkg and the audio_gain_pan_ramp RTL.
`timescale 1ns / 1ps

module tb;
    import agpr_pkg::*;

    localparam int                CLK_HALF    = 10;
    localparam int                RESET_CYCLES = 7;
    localparam int                SETTLE_CYCLES = 60;   // longest transaction plus margin
    localparam int                CYCLE_LIMIT = 600000;
    localparam int                PHASE_ITEMS = 150;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;   // undefined code, ignored by the block

    // Scoreboard: mirrors the ramp state and holds the expected scaled samples
    class ramp_scoreboard;
        logic [CFG_W-1:0]       pan_count;
        logic [CFG_W-1:0]       ramp_count;
        bit                     applied_once;
        logic [Q14_W-1:0]       applied_gain;
        logic [Q14_W-1:0]       applied_pan [DEF_MAX_CHANNELS];
        logic [Q14_W-1:0]       ramp_start_gain;
        bit                     ramp_active;
        int unsigned            block_samples;
        int unsigned            block_channels;
        longint unsigned        from_factor;
        longint                 factor_step;
        t_agpr_out              scaled_q [$];
        int                     mismatches;
        int                     samples_checked;
        int                     clipped_seen;

        function new();
            pan_count       = '0;
            ramp_count      = '0;
            applied_once    = 1'b0;
            applied_gain    = '0;
            foreach (applied_pan[i]) applied_pan[i] = '0;
            ramp_start_gain = '0;
            ramp_active     = 1'b0;
            block_samples   = 1;
            block_channels  = 0;
            from_factor     = 0;
            factor_step     = 0;
            mismatches      = 0;
            samples_checked = 0;
            clipped_seen    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_PAN_COUNT)
                pan_count = val;
            else if (idx == CFG_RAMP_COUNT)
                ramp_count = val;
        endfunction

        // Update the ramp state for one accepted transaction; queue a result for samples
        function void apply_input(t_agpr_in t);
            int unsigned     len;
            int unsigned     chans;
            int unsigned     ch;
            int unsigned     pos;
            longint unsigned to_pan;
            longint unsigned src_pan;
            longint unsigned to_f;
            longint          term;
            longint          smp;
            longint unsigned fac;
            longint unsigned mag;
            longint unsigned rnd;
            longint unsigned lim;
            longint unsigned res;
            bit              neg;
            bit              clip;
            t_agpr_out       e;

            case (t.func)
                FUNC_BLOCK: begin
                    len   = t.block_length;
                    chans = t.channel_total;
                    if (chans != 0) begin
                        if (chans > DEF_MAX_CHANNELS) chans = DEF_MAX_CHANNELS;
                        if (len == 0) len = 1;
                        if (len > DEF_MAX_BLOCK) len = DEF_MAX_BLOCK;
                        ramp_active     = applied_once;
                        ramp_start_gain = applied_once ? applied_gain : t.gain_target;
                        applied_once    = 1'b1;
                        applied_gain    = t.gain_target;
                        block_samples   = len;
                        block_channels  = chans;
                    end
                end
                FUNC_CHAN: begin
                    ch = t.channel_number;
                    if (ch < block_channels && ch < DEF_MAX_CHANNELS) begin
                        // mono blocks and channels without a pan run at unity
                        to_pan = (block_channels == 1 || ch >= pan_count) ?
                                 UNITY_Q14 : t.pan_target;
                        src_pan = to_pan;
                        if (ch < ramp_count) begin
                            if (ramp_active) src_pan = applied_pan[ch[CHAN_W-1:0]];
                            applied_pan[ch[CHAN_W-1:0]] = to_pan[Q14_W-1:0];
                        end
                        from_factor = longint'(ramp_start_gain) * src_pan;
                        to_f        = longint'(applied_gain) * to_pan;
                        factor_step = longint'(to_f) - longint'(from_factor);
                    end
                end
                FUNC_SAMPLE: begin
                    pos = t.sample_position;
                    if (pos >= block_samples) pos = block_samples - 1;
                    // ramp term truncates toward zero
                    term = (factor_step * longint'(pos + 1)) / longint'(block_samples);
                    fac  = longint'(from_factor) + term;
                    smp  = $signed(t.sample_in);
                    neg  = smp < 0;
                    mag  = neg ? -smp : smp;
                    // round half away from zero on the magnitude, then saturate
                    rnd  = (mag * fac + (64'd1 << (FACTOR_SHIFT - 1))) >> FACTOR_SHIFT;
                    lim  = 64'd1 << (SAMPLE_BITS - 1);
                    clip = 1'b0;
                    if (!neg && rnd > lim - 1) begin
                        rnd  = lim - 1;
                        clip = 1'b1;
                    end else if (neg && rnd > lim) begin
                        rnd  = lim;
                        clip = 1'b1;
                    end
                    res           = neg ? (64'd0 - rnd) : rnd;
                    e.sample_out  = res[SAMPLE_BITS-1:0];
                    e.channel_out = t.channel_number;
                    e.clipped     = clip;
                    scaled_q.push_back(e);
                end
                default: ;
            endcase
        endfunction

        function void report(string field, longint exp_v, longint act_v);
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v,
                     act_v);
        endfunction

        // Compare one output transaction with the oldest expected sample
        function void check_sample(t_agpr_out got);
            t_agpr_out e;

            if (scaled_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output, expected none, actual sample %0d ch %0d",
                         $time, got.sample_out, got.channel_out);
            end else begin
                e = scaled_q.pop_front();
                samples_checked++;
                if (e.clipped) clipped_seen++;
                if (got.sample_out !== e.sample_out)
                    report("sample_out", e.sample_out, $signed(got.sample_out));
                if (got.channel_out !== e.channel_out)
                    report("channel_out", e.channel_out, got.channel_out);
                if (got.clipped !== e.clipped)
                    report("clipped", e.clipped, got.clipped);
            end
        endfunction

        function int pending();
            return scaled_q.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_agpr_in             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_agpr_out            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    ramp_scoreboard sb = new();
    bit             quiet = 1'b0;    // no idling on either side while set
    int             cycles = 0;
    int             work_items = 0;
    int             blocks_sent = 0;
    int             chans_sent = 0;
    int             samples_sent = 0;
    int             settings_used = 0;

    audio_gain_pan_ramp DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d samples outstanding", cycles,
                     sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int pick_wait();
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic [Q14_W-1:0] pick_q14();
        case ($urandom_range(0, 3))
            0: return Q14_W'($urandom_range(0, 65535));
            1: return Q14_W'(UNITY_Q14 + $urandom_range(0, 64) - 32);
            2: return Q14_W'($urandom_range(0, UNITY_Q14));
            default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
        endcase
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 5))
            0: return ($urandom_range(0, 1) == 0) ? 24'h800000 : 24'h7FFFFF;
            1: return SAMPLE_BITS'($urandom_range(0, 2047) - 1024);
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    function automatic t_agpr_in noise_item();
        logic [95:0] raw;

        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(t_agpr_in)-1:0];
    endfunction

    // Drive one input transaction and wait for it to be taken
    task automatic send(t_agpr_in it);
        int gap;

        gap = pick_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.apply_input(it);
        if (it.func != FUNC_NONE) work_items++;
        if (it.func == FUNC_BLOCK) blocks_sent++;
        if (it.func == FUNC_CHAN) chans_sent++;
        if (it.func == FUNC_SAMPLE) samples_sent++;
    endtask

    task automatic send_block(logic [Q14_W-1:0] gain, logic [LEN_W-1:0] len,
                              logic [CHCNT_W-1:0] chans);
        t_agpr_in it;

        it               = noise_item();
        it.func          = FUNC_BLOCK;
        it.gain_target   = gain;
        it.block_length  = len;
        it.channel_total = chans;
        send(it);
    endtask

    task automatic send_chan(logic [CHAN_W-1:0] ch, logic [Q14_W-1:0] pan);
        t_agpr_in it;

        it                = noise_item();
        it.func           = FUNC_CHAN;
        it.channel_number = ch;
        it.pan_target     = pan;
        send(it);
    endtask

    task automatic send_sample(logic [CHAN_W-1:0] ch, logic [POS_W-1:0] pos,
                               logic [SAMPLE_BITS-1:0] val);
        t_agpr_in it;

        it                 = noise_item();
        it.func            = FUNC_SAMPLE;
        it.channel_number  = ch;
        it.sample_position = pos;
        it.sample_in       = val;
        send(it);
    endtask

    // Write both registers back to back; call only while the block is idle
    task automatic program_regs(logic [CFG_W-1:0] pan_cnt, logic [CFG_W-1:0] ramp_cnt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PAN_COUNT;
        i_cfg_data  <= pan_cnt;
        @(posedge i_clk);
        sb.write_reg(CFG_PAN_COUNT, pan_cnt);
        i_cfg_index <= CFG_RAMP_COUNT;
        i_cfg_data  <= ramp_cnt;
        @(posedge i_clk);
        sb.write_reg(CFG_RAMP_COUNT, ramp_cnt);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Let every expected sample come out, then give trailing work time to settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Directed corner cases, run with pan count 3 and ramp count 2
    task automatic directed();
        t_agpr_in it;

        send_sample(4'd7, 12'd0, 24'h7FFFFF);             // nothing started: zero factor
        it      = noise_item();
        it.func = FUNC_NONE;
        send(it);
        send_block(16'h1234, 13'd10, 5'd0);               // empty block, no effect
        send_block(16'hFFFF, 13'd0, 5'd31);               // length and count clamp, no ramp
        send_chan(4'd0, 16'hFFFF);
        send_sample(4'd0, 12'd4095, 24'h800000);          // negative full scale clips
        send_sample(4'd0, 12'd0, 24'h7FFFFF);             // positive clip
        send_chan(4'd5, 16'h0000);                        // beyond pan count: unity
        send_sample(4'd5, 12'd0, 24'hFFFFFF);
        send_block(UNITY_Q14, 13'd8191, 5'd1);            // mono, long block clamps
        send_chan(4'd0, 16'h0000);                        // pan forced to unity, ramped
        send_sample(4'd0, 12'd0, 24'd1000);
        send_sample(4'd0, 12'd2047, 24'h123456);
        send_sample(4'd0, 12'd4095, 24'hEDCBAA);
        send_chan(4'd3, 16'h8000);                        // outside block: ignored
        send_sample(4'd3, 12'd100, 24'd12345);            // uses last channel's ramp
        send_block(16'h0000, 13'd4, 5'd16);               // ramp down to zero gain
        send_chan(4'd15, 16'h8000);
        send_sample(4'd15, 12'd3, 24'h000000);
        send_chan(4'd1, UNITY_Q14);
        send_sample(4'd1, 12'd1, 24'hC00000);
        send_chan(4'd2, 16'hAAAA);                        // pan used but not remembered
        send_sample(4'd2, 12'd0, 24'h3FFFFF);
        send_sample(4'd2, 12'd2, 24'hC00001);
    endtask

    // Random traffic: mostly whole blocks, with broken sequences and noise mixed in
    task automatic run_random(int quota);
        int          first;
        int          roll;
        int unsigned chans;
        int unsigned len;
        int unsigned eff;
        int unsigned nch;
        int unsigned nsmp;
        int unsigned pos;
        t_agpr_in    it;

        first = work_items;
        while (work_items - first < quota) begin
            roll = $urandom_range(0, 9);
            if (roll == 0) begin
                it      = noise_item();
                send(it);
            end else if (roll == 1) begin
                case ($urandom_range(0, 2))
                    0: send_chan(CHAN_W'($urandom_range(0, 15)), pick_q14());
                    1: send_sample(CHAN_W'($urandom_range(0, 15)),
                                   POS_W'($urandom_range(0, 4095)), pick_sample());
                    default: send_block(pick_q14(), LEN_W'($urandom_range(0, 8191)),
                                        CHCNT_W'($urandom_range(0, 31)));
                endcase
            end else begin
                chans = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 31) :
                                                      $urandom_range(1, 4);
                len   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) :
                                                      $urandom_range(1, 16);
                eff   = (len == 0) ? 1 : (len > DEF_MAX_BLOCK ? DEF_MAX_BLOCK : len);
                nch   = (chans > DEF_MAX_CHANNELS) ? DEF_MAX_CHANNELS : chans;
                send_block(pick_q14(), LEN_W'(len), CHCNT_W'(chans));
                for (int c = 0; c < nch; c++) begin
                    if ($urandom_range(0, 5) != 0) send_chan(CHAN_W'(c), pick_q14());
                    nsmp = (nch > 4) ? $urandom_range(1, 2) : $urandom_range(1, 6);
                    for (int k = 0; k < nsmp; k++) begin
                        if ($urandom_range(0, 7) == 0)
                            pos = $urandom_range(0, 4095);
                        else if ($urandom_range(0, 3) == 0)
                            pos = eff - 1;
                        else
                            pos = $urandom_range(0, eff - 1);
                        send_sample(CHAN_W'(c), POS_W'(pos), pick_sample());
                    end
                end
            end
        end
    endtask

    // Output side: random stall before each result, then take it
    initial begin
        int n;

        wait (i_rst_n === 1'b1);
        forever begin
            n = pick_wait();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            sb.check_sample(o_out_data);
        end
    end

    // Main sequence
    initial begin
        logic [CFG_W-1:0] pan_cnt;
        logic [CFG_W-1:0] ramp_cnt;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        program_regs(5'd3, 5'd2);
        directed();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin pan_cnt = 5'd16; ramp_cnt = 5'd16; end
                1: begin pan_cnt = 5'd0;  ramp_cnt = 5'd0;  end
                2: begin pan_cnt = 5'd16; ramp_cnt = 5'd0;  end
                3: begin pan_cnt = 5'd0;  ramp_cnt = 5'd16; end
                default: begin
                    pan_cnt  = CFG_W'($urandom_range(0, 16));
                    ramp_cnt = CFG_W'($urandom_range(0, 16));
                end
            endcase
            quiet = (ph == 2);
            program_regs(pan_cnt, ramp_cnt);
            run_random(PHASE_ITEMS);
            drain();
        end

        $display("sent %0d block starts, %0d channel starts, %0d samples over %0d settings",
                 blocks_sent, chans_sent, samples_sent, settings_used);
        $display("checked %0d scaled samples, %0d of them saturated, %0d mismatches",
                 sb.samples_checked, sb.clipped_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
